// ----- hdl/gmn_pkg.sv -----
// Package with the shared widths, codes and queue entry type of the gray16 normalizer.
package gmn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GRAY_W = 8;
  localparam int DIVIDEND_W = SAMPLE_W + GRAY_W;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SAMPLE_W-1:0] MIN_RESET = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] MAX_RESET = 16'h0000;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_MAP = 1'b1;

  typedef struct packed {
    logic pass;
    logic [GRAY_W-1:0] raw;
    logic [SAMPLE_W-1:0] numer;
    logic [SAMPLE_W-1:0] span;
  } qent_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

endpackage

// ----- hdl/gmn_req_if.sv -----
// Interface of the request channel carrying samples into the normalizer.
interface gmn_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [gmn_pkg::SAMPLE_W-1:0] sample;
  logic first;

  modport source (output valid, output req_type, output sample, output first, input ready);
  modport sink (input valid, input req_type, input sample, input first, output ready);
endinterface

// ----- hdl/gmn_res_if.sv -----
// Interface of the result channel carrying stretched gray values.
interface gmn_res_if;
  logic valid;
  logic ready;
  logic [gmn_pkg::GRAY_W-1:0] gray;

  modport source (output valid, output gray, input ready);
  modport sink (input valid, input gray, output ready);
endinterface

// ----- hdl/gmn_front.sv -----
// Front end: accepts requests, tracks min and max, and queues map jobs.
module gmn_front (
  input  logic               clk,
  input  logic               rst,
  gmn_req_if.sink            req,
  input  gmn_pkg::qstat_t    qstat,
  output logic               push,
  output gmn_pkg::qent_t     wr_ent
);

  logic [gmn_pkg::SAMPLE_W-1:0] min_seen;
  logic [gmn_pkg::SAMPLE_W-1:0] max_seen;
  logic [gmn_pkg::SAMPLE_W-1:0] clamped;
  logic                         take;

  assign req.ready = !qstat.full;
  assign take = req.valid && !qstat.full;
  assign push = take && (req.req_type == gmn_pkg::REQ_MAP);

  always_comb begin
    if (req.sample < min_seen) begin
      clamped = min_seen;
    end else if (req.sample > max_seen) begin
      clamped = max_seen;
    end else begin
      clamped = req.sample;
    end
    wr_ent.pass = (max_seen <= min_seen);
    wr_ent.raw = req.sample[gmn_pkg::SAMPLE_W-1 -: gmn_pkg::GRAY_W];
    wr_ent.numer = clamped - min_seen;
    wr_ent.span = max_seen - min_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen <= gmn_pkg::MIN_RESET;
      max_seen <= gmn_pkg::MAX_RESET;
    end else if (take && (req.req_type == gmn_pkg::REQ_MEASURE)) begin
      if (req.first) begin
        min_seen <= req.sample;
        max_seen <= req.sample;
      end else begin
        if (req.sample < min_seen) begin
          min_seen <= req.sample;
        end
        if (req.sample > max_seen) begin
          max_seen <= req.sample;
        end
      end
    end
  end

endmodule

// ----- hdl/gmn_fifo.sv -----
// Short queue of map jobs between the front end and the divider.
module gmn_fifo #(
  parameter int DEPTH = gmn_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gmn_pkg::qent_t  wr_ent,
  input  logic            pop,
  output gmn_pkg::qent_t  rd_ent,
  output gmn_pkg::qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  gmn_pkg::qent_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full = (count == FULL_CNT);
  assign qstat.nonempty = (count != '0);
  assign rd_ent = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("Queue count exceeds its depth.");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && qstat.full && !pop))
    else $error("Push into a full queue.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !qstat.nonempty))
    else $error("Pop from an empty queue.");
`endif

endmodule

// ----- hdl/gmn_back.sv -----
// Back end: rounds and divides queued map jobs one quotient bit per cycle, waiting on the last bit while res stalls.
module gmn_back (
  input  logic            clk,
  input  logic            rst,
  input  gmn_pkg::qent_t  rd_ent,
  input  gmn_pkg::qstat_t qstat,
  output logic            pop,
  gmn_res_if.source       res
);

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  localparam int DW = gmn_pkg::DIVIDEND_W;
  localparam int SW = gmn_pkg::SAMPLE_W;
  localparam int GW = gmn_pkg::GRAY_W;

  state_t          state;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dsh;
  logic [GW-1:0]   quo;
  logic [2:0]      cnt;
  logic            ovalid;
  logic [GW-1:0]   ogray;
  logic            out_free;
  logic            fits;
  logic [DW-1:0]   dividend;

  assign res.valid = ovalid;
  assign res.gray = ogray;
  assign out_free = !ovalid || res.ready;
  assign pop = (state == ST_IDLE) && qstat.nonempty && out_free;
  assign fits = (rem >= dsh);
  assign dividend = {rd_ent.numer, {GW{1'b0}}} - {{GW{1'b0}}, rd_ent.numer}
                    + {{(GW+1){1'b0}}, rd_ent.span[SW-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ovalid <= 1'b0;
      cnt <= '0;
    end else begin
      if (ovalid && res.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (rd_ent.pass) begin
              ovalid <= 1'b1;
              ogray <= rd_ent.raw;
            end else begin
              rem <= dividend;
              dsh <= {1'b0, rd_ent.span, {(GW-1){1'b0}}};
              quo <= '0;
              cnt <= 3'd7;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (cnt != 3'd0 || out_free) begin
            if (fits) begin
              rem <= rem - dsh;
            end
            quo <= {quo[GW-2:0], fits};
            dsh <= {1'b0, dsh[DW-1:1]};
            cnt <= cnt - 1'b1;
            if (cnt == 3'd0) begin
              ovalid <= 1'b1;
              ogray <= {quo[GW-2:0], fits};
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (dsh != '0))
    else $error("Divider running with a zero divisor.");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE && qstat.nonempty))
    else $error("Job taken from the queue while the divider is busy.");
  a_result_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == 3'd0 && ovalid && !res.ready) |=> (state == ST_DIV))
    else $error("Divider finished while the result register was occupied.");
`endif

endmodule

// ----- hdl/gray16_minmax_normalizer_unit.sv -----
// Top level of the 16-bit to 8-bit min-max contrast stretch normalizer.
//
// The req channel carries one sample per transaction with req_type and first.
// A measure transaction folds its sample into the running minimum and maximum
// (first restarts them from the sample) and produces no result. A map
// transaction produces one gray value on the res channel, stretched so that
// the minimum maps to 0 and the maximum to 255, with rounding.
// The front end takes a measure transaction every cycle while the queue is not
// full; map jobs are queued with a snapshot of the bounds, so later measures
// do not affect them. The back end divides one quotient bit per cycle while
// res does not stall: a map job takes one setup step and eight divide steps,
// or passes on the top byte of its sample when the range is flat or nothing
// has been measured. It takes a new job from the queue only when it is idle
// and its result register is free.
// When res stalls, the result holds in its output register, the divider
// waits on its last step, and req keeps accepting until the queue fills.
// Synchronous reset empties the queue, drops any pending result and sets the
// bounds to their empty state (minimum 0xFFFF, maximum 0).
module gray16_minmax_normalizer_unit #(
  parameter int QUEUE_DEPTH = gmn_pkg::QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  gmn_req_if.sink   req,
  gmn_res_if.source res
);

  gmn_pkg::qent_t  wr_ent;
  gmn_pkg::qent_t  rd_ent;
  gmn_pkg::qstat_t qstat;
  logic            push;
  logic            pop;

  gmn_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .qstat  (qstat),
    .push   (push),
    .wr_ent (wr_ent)
  );

  gmn_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_ent (wr_ent),
    .pop    (pop),
    .rd_ent (rd_ent),
    .qstat  (qstat)
  );

  gmn_back u_back (
    .clk    (clk),
    .rst    (rst),
    .rd_ent (rd_ent),
    .qstat  (qstat),
    .pop    (pop),
    .res    (res)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the 16-bit to 8-bit min-max contrast stretch normalizer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 600;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int N_DIR = 25;

  typedef struct packed {
    logic req_type;
    logic [gmn_pkg::SAMPLE_W-1:0] sample;
    logic restart;
    logic fixed;
    logic [gmn_pkg::GRAY_W-1:0] gray;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gmn_req_if req_ch();
  gmn_res_if res_ch();

  gray16_minmax_normalizer_unit u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  logic [gmn_pkg::SAMPLE_W-1:0] min_q;
  logic [gmn_pkg::SAMPLE_W-1:0] max_q;
  logic [gmn_pkg::GRAY_W-1:0] gray_expected_q[$];
  dir_row_t dir_rows[N_DIR];

  int unsigned src_idle_pct = 14;
  int unsigned sink_idle_pct = 82;
  bit hold_trigger = 1'b0;

  int unsigned items_sent = 0;
  int unsigned maps_sent = 0;
  int unsigned results_checked = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [gmn_pkg::GRAY_W-1:0] stretch_gray(
      logic [gmn_pkg::SAMPLE_W-1:0] s);
    logic [gmn_pkg::SAMPLE_W-1:0] c;
    int unsigned range;
    int unsigned offset;
    int unsigned q;
    if (max_q <= min_q) begin
      return s[gmn_pkg::SAMPLE_W-1:gmn_pkg::SAMPLE_W-gmn_pkg::GRAY_W];
    end
    c = s;
    if (c < min_q) begin
      c = min_q;
    end
    if (c > max_q) begin
      c = max_q;
    end
    range = 32'(max_q - min_q);
    offset = 32'(c - min_q);
    q = (offset * 255 + range / 2) / range;
    if (q > 255) begin
      q = 255;
    end
    return q[gmn_pkg::GRAY_W-1:0];
  endfunction

  function automatic void fold_measure(logic [gmn_pkg::SAMPLE_W-1:0] s, logic restart);
    if (restart) begin
      min_q = s;
      max_q = s;
    end else begin
      if (s < min_q) begin
        min_q = s;
      end
      if (s > max_q) begin
        max_q = s;
      end
    end
  endfunction

  function automatic logic [gmn_pkg::SAMPLE_W-1:0] near_sample(int unsigned lo,
                                                               int unsigned span);
    int unsigned v;
    v = lo + $urandom_range(span);
    if (v > 65535) begin
      v = 65535;
    end
    return v[gmn_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic send_item(input logic kind, input logic [gmn_pkg::SAMPLE_W-1:0] s,
                           input logic restart, input logic fixed,
                           input logic [gmn_pkg::GRAY_W-1:0] fixed_gray);
    logic [gmn_pkg::GRAY_W-1:0] gray_pred;
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.sample <= s;
    req_ch.first <= restart;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    items_sent++;
    if (kind == gmn_pkg::REQ_MAP) begin
      gray_pred = stretch_gray(s);
      gray_expected_q.insert(gray_expected_q.size(), fixed ? fixed_gray : gray_pred);
      maps_sent++;
    end else begin
      fold_measure(s, restart);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (gray_expected_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned target;
    int unsigned lo;
    int unsigned span;
    int unsigned n_meas;
    int unsigned n_map;
    logic [gmn_pkg::SAMPLE_W-1:0] s;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 15) begin
        send_item(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)), 1'b0, '0);
      end else begin
        lo = $urandom_range(65535);
        case ($urandom_range(3))
          0: span = 0;
          1: span = $urandom_range(3);
          2: span = $urandom_range(4095);
          default: span = 65535;
        endcase
        send_item(gmn_pkg::REQ_MEASURE, near_sample(lo, span), 1'b1, 1'b0, '0);
        n_meas = $urandom_range(10);
        repeat (n_meas) begin
          send_item(gmn_pkg::REQ_MEASURE, near_sample(lo, span),
                    1'($urandom_range(19) == 0), 1'b0, '0);
        end
        n_map = $urandom_range(12, 1);
        repeat (n_map) begin
          case ($urandom_range(7))
            0: s = 16'($urandom);
            1: s = '0;
            2: s = '1;
            default: s = near_sample(lo, span);
          endcase
          send_item(gmn_pkg::REQ_MAP, s, 1'($urandom_range(1)), 1'b0, '0);
        end
      end
    end
  endtask

  initial begin : sink_proc
    int unsigned stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger) begin
        stall_left = LONG_HOLD;
        hold_trigger = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && !req_ch.ready) begin
        stall_cycles++;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (gray_expected_q.size() == 0) begin
          $error("gray: result %0d arrived with nothing expected", res_ch.gray);
          fail_count++;
        end else begin
          if (res_ch.gray !== gray_expected_q[0]) begin
            $error("gray mismatch: expected %0d, actual %0d", gray_expected_q[0], res_ch.gray);
            fail_count++;
          end
          void'(gray_expected_q.pop_front());
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected.",
               cycle_count, gray_expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = gmn_pkg::REQ_MEASURE;
    req_ch.sample = '0;
    req_ch.first = 1'b0;

    dir_rows = '{
      '{gmn_pkg::REQ_MAP,     16'hFFFF, 1'b0, 1'b1, 8'hFF},
      '{gmn_pkg::REQ_MAP,     16'h0000, 1'b1, 1'b1, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'h1234, 1'b0, 1'b1, 8'h12},
      '{gmn_pkg::REQ_MEASURE, 16'h1000, 1'b1, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'h1080, 1'b0, 1'b1, 8'h10},
      '{gmn_pkg::REQ_MEASURE, 16'h2000, 1'b0, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'h1000, 1'b0, 1'b1, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'h2000, 1'b0, 1'b1, 8'hFF},
      '{gmn_pkg::REQ_MAP,     16'h0000, 1'b0, 1'b1, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'hFFFF, 1'b0, 1'b1, 8'hFF},
      '{gmn_pkg::REQ_MAP,     16'h1800, 1'b1, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MEASURE, 16'h1800, 1'b0, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'h17FF, 1'b0, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MEASURE, 16'h0000, 1'b1, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MEASURE, 16'hFFFF, 1'b0, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'h8000, 1'b0, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'h0001, 1'b0, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'hFFFE, 1'b0, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MEASURE, 16'hFFFF, 1'b1, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'hFFFF, 1'b0, 1'b1, 8'hFF},
      '{gmn_pkg::REQ_MAP,     16'h0000, 1'b0, 1'b1, 8'h00},
      '{gmn_pkg::REQ_MEASURE, 16'h0000, 1'b1, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MEASURE, 16'h0001, 1'b0, 1'b0, 8'h00},
      '{gmn_pkg::REQ_MAP,     16'h0001, 1'b0, 1'b1, 8'hFF},
      '{gmn_pkg::REQ_MAP,     16'h0000, 1'b0, 1'b1, 8'h00}
    };

    min_q = gmn_pkg::MIN_RESET;
    max_q = gmn_pkg::MAX_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      send_item(dir_rows[i].req_type, dir_rows[i].sample, dir_rows[i].restart,
                dir_rows[i].fixed, dir_rows[i].gray);
    end
    run_random(PHASE_ITEMS);
    wait_drained();

    src_idle_pct = 82;
    sink_idle_pct = 14;
    run_random(PHASE_ITEMS);
    wait_drained();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_trigger = 1'b1;
    run_random(PHASE_ITEMS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions (%0d maps), checked %0d gray results.",
             items_sent, maps_sent, results_checked);
    $display("Input was held off for %0d cycles across the three traffic phases.",
             stall_cycles);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
